// ----- sv/image_header_size_sniffer_macros.svh -----
// ----------------------------------------------------------------------------
// image header size sniffer: assertion macros
// shared concurrent check forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH
`define IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define IHSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IHSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ihss_pkg.sv -----
// ----------------------------------------------------------------------------
// ihss_pkg
// shared types and format codes of the image header size sniffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihss_pkg;

    // format codes as reported on the result word
    localparam logic [2:0] FMT_UNKNOWN = 3'd0;
    localparam logic [2:0] FMT_JPEG    = 3'd1;
    localparam logic [2:0] FMT_PNG     = 3'd2;
    localparam logic [2:0] FMT_GIF     = 3'd3;
    localparam logic [2:0] FMT_WEBP    = 3'd4;

    // jpeg frame header status, next-state view from the marker walker
    typedef struct packed {
        logic        found;
        logic [31:0] size;   // height in 31..16, width in 15..0
    } ihss_frame_t;

endpackage

// ----- sv/ihss_jpeg_walk.sv -----
// ----------------------------------------------------------------------------
// ihss_jpeg_walk
// walks jpeg marker segments from offset 2 up to the first sof header and
// captures the frame height and width; cleared at the end of every file
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "image_header_size_sniffer_macros.svh"

module ihss_jpeg_walk #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step_en,
    input  logic                    file_end,
    input  logic [OFFSET_BITS-1:0]  offset,
    input  logic [7:0]              data_byte,
    output ihss_pkg::ihss_frame_t   frame_next
);
    import ihss_pkg::*;

    localparam logic PHASE_HEADER = 1'b0;
    localparam logic PHASE_FRAME  = 1'b1;
    localparam logic [OFFSET_BITS-1:0] START_RESET = OFFSET_BITS'(2);

    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [7:0]             len_hi_reg, len_hi_next;
    logic [7:0]             marker_reg, marker_next;
    logic                   phase_reg, phase_next;
    logic [31:0]            size_reg, size_next;
    logic                   found_reg, found_next;
    logic                   stopped_reg, stopped_next;

    logic [OFFSET_BITS-1:0] seg_k;
    logic                   walk_active;
    logic [15:0]            len_full;
    logic [OFFSET_BITS:0]   start_sum;

    function automatic logic is_sof(input logic [7:0] m);
        is_sof = (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
    endfunction

    // position inside the current segment and next segment start
    assign seg_k       = offset - start_reg;
    assign walk_active = step_en && !stopped_reg && !found_reg && (offset >= start_reg);
    assign len_full    = {len_hi_reg, data_byte};
    assign start_sum   = {1'b0, start_reg} + (OFFSET_BITS+1)'(len_full)
                         + (OFFSET_BITS+1)'(2);

    // segment header and frame header byte capture
    always_comb
    begin
        start_next   = start_reg;
        len_hi_next  = len_hi_reg;
        marker_next  = marker_reg;
        phase_next   = phase_reg;
        size_next    = size_reg;
        found_next   = found_reg;
        stopped_next = stopped_reg;
        if (walk_active)
        begin
            priority if (seg_k == OFFSET_BITS'(0))
            begin
                if (data_byte != 8'hFF)
                    stopped_next = 1'b1;
            end
            else if (seg_k == OFFSET_BITS'(1))
                marker_next = data_byte;
            else if (seg_k == OFFSET_BITS'(2))
                len_hi_next = data_byte;
            else if (seg_k == OFFSET_BITS'(3))
            begin
                if (is_sof(marker_reg))
                    phase_next = PHASE_FRAME;
                else if (len_full < 16'd2)
                    stopped_next = 1'b1;
                else if (start_sum[OFFSET_BITS])
                    start_next = '1;
                else
                    start_next = start_sum[OFFSET_BITS-1:0];
            end
            else if (phase_reg == PHASE_FRAME)
            begin
                priority if (seg_k == OFFSET_BITS'(5))
                    size_next[31:24] = data_byte;
                else if (seg_k == OFFSET_BITS'(6))
                    size_next[23:16] = data_byte;
                else if (seg_k == OFFSET_BITS'(7))
                    size_next[15:8] = data_byte;
                else if (seg_k == OFFSET_BITS'(8))
                    size_next[7:0] = data_byte;
                else if (seg_k == OFFSET_BITS'(9))
                    found_next = 1'b1;
                else
                    found_next = found_reg;
            end
            else
                phase_next = phase_reg;
        end
    end

    assign frame_next.found = found_next;
    assign frame_next.size  = size_next;

    // walk state, back to its start values after each file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= START_RESET;
            len_hi_reg  <= 8'd0;
            marker_reg  <= 8'd0;
            phase_reg   <= PHASE_HEADER;
            size_reg    <= 32'd0;
            found_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (file_end)
        begin
            start_reg   <= START_RESET;
            len_hi_reg  <= 8'd0;
            marker_reg  <= 8'd0;
            phase_reg   <= PHASE_HEADER;
            size_reg    <= 32'd0;
            found_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            start_reg   <= start_next;
            len_hi_reg  <= len_hi_next;
            marker_reg  <= marker_next;
            phase_reg   <= phase_next;
            size_reg    <= size_next;
            found_reg   <= found_next;
            stopped_reg <= stopped_next;
        end
    end

    // checks
    `IHSS_ASSERT_NOW(a_found_in_frame, found_reg, phase_reg == PHASE_FRAME, "frame found outside frame phase")
    `IHSS_ASSERT_NOW(a_found_not_stopped, found_reg, !stopped_reg, "walk both stopped and found")
    `IHSS_ASSERT_NEXT(a_clear_on_end, file_end, !found_reg && !stopped_reg && start_reg == START_RESET, "walk not cleared after file end")

endmodule

// ----- sv/image_header_size_sniffer.sv -----
// ----------------------------------------------------------------------------
// image_header_size_sniffer
// reads an image file one byte per word and on the last byte reports the
// format (jpeg, png, gif, webp or unknown) with the width and height from its header
// ----------------------------------------------------------------------------
//  channel   dir  handshake            words
//  input     in   in_valid/in_ready    data_byte, last_byte
//  result    out  out_valid/out_ready  format, width, height, size_valid
//
//  one byte is taken per cycle unless a held result stalls a last byte: an input
//  register, then the header window, offset counter and jpeg walker update from it
//  a result word is loaded into the result register as its last byte leaves the input register
//  a held result stalls only a following last byte; other bytes keep flowing
//  reset clears the offset, walker and handshake state; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "image_header_size_sniffer_macros.svh"

module image_header_size_sniffer #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  format,
    output logic [31:0] width,
    output logic [31:0] height,
    output logic        size_valid
);
    import ihss_pkg::*;

    localparam int WIN_LEN = 30;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    // input register
    logic        a_valid_reg;
    logic [7:0]  a_byte_reg;
    logic        a_last_reg;
    logic        a_adv;

    // file state
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   offset_live;
    logic [7:0]             win_reg  [WIN_LEN];
    logic [7:0]             win_next [WIN_LEN];
    ihss_frame_t            frame_next;

    // result register
    logic        out_valid_reg;
    logic [2:0]  format_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;
    logic        size_valid_reg;

    // decode
    logic [2:0]  fmt_c;
    logic [31:0] w_c;
    logic [31:0] h_c;
    logic        found_c;
    logic [31:0] vp8l_bits;

    // handshake: the input register moves on unless a last byte meets a held result
    assign a_adv    = a_valid_reg && (!a_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_byte_reg <= data_byte;
            a_last_reg <= last_byte;
        end
    end

    // saturating byte offset; the next value is also the file length so far
    assign offset_live = (offset_reg != OFFSET_MAX);
    assign offset_next = offset_live ? offset_reg + OFFSET_BITS'(1) : offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (a_adv)
            offset_reg <= a_last_reg ? '0 : offset_next;
    end

    // header window of the first bytes of the file
    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
            win_next[i] = (offset_reg == OFFSET_BITS'(i)) ? a_byte_reg : win_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            for (int i = 0; i < WIN_LEN; i++)
                win_reg[i] <= win_next[i];
        end
    end

    // jpeg marker walker
    ihss_jpeg_walk #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (a_adv && offset_live),
        .file_end   (a_adv && a_last_reg),
        .offset     (offset_reg),
        .data_byte  (a_byte_reg),
        .frame_next (frame_next)
    );

    assign vp8l_bits = {win_next[24], win_next[23], win_next[22], win_next[21]};

    // signature match and size pick, settled against the file length
    always_comb
    begin
        fmt_c   = FMT_UNKNOWN;
        w_c     = 32'd0;
        h_c     = 32'd0;
        found_c = 1'b0;
        if (offset_next >= OFFSET_BITS'(12))
        begin
            priority if (win_next[0] == 8'hFF && win_next[1] == 8'hD8 && win_next[2] == 8'hFF)
            begin
                fmt_c = FMT_JPEG;
                if (frame_next.found)
                begin
                    h_c     = {16'd0, frame_next.size[31:16]};
                    w_c     = {16'd0, frame_next.size[15:0]};
                    found_c = 1'b1;
                end
            end
            else if (win_next[0] == 8'h89 && win_next[1] == "P" && win_next[2] == "N"
                     && win_next[3] == "G" && win_next[4] == 8'h0D && win_next[5] == 8'h0A
                     && win_next[6] == 8'h1A && win_next[7] == 8'h0A)
            begin
                fmt_c = FMT_PNG;
                if (offset_next >= OFFSET_BITS'(24) && win_next[12] == "I"
                    && win_next[13] == "H" && win_next[14] == "D" && win_next[15] == "R")
                begin
                    w_c     = {win_next[16], win_next[17], win_next[18], win_next[19]};
                    h_c     = {win_next[20], win_next[21], win_next[22], win_next[23]};
                    found_c = 1'b1;
                end
            end
            else if (win_next[0] == "G" && win_next[1] == "I" && win_next[2] == "F"
                     && win_next[3] == "8" && (win_next[4] == "7" || win_next[4] == "9")
                     && win_next[5] == "a")
            begin
                fmt_c   = FMT_GIF;
                w_c     = {16'd0, win_next[7], win_next[6]};
                h_c     = {16'd0, win_next[9], win_next[8]};
                found_c = 1'b1;
            end
            else if (win_next[0] == "R" && win_next[1] == "I" && win_next[2] == "F"
                     && win_next[3] == "F")
            begin
                fmt_c = FMT_WEBP;
                if (offset_next >= OFFSET_BITS'(16) && win_next[8] == "W"
                    && win_next[9] == "E" && win_next[10] == "B" && win_next[11] == "P"
                    && win_next[12] == "V" && win_next[13] == "P" && win_next[14] == "8")
                begin
                    priority if (win_next[15] == " ")
                    begin
                        if (offset_next >= OFFSET_BITS'(30))
                        begin
                            w_c     = {18'd0, win_next[27][5:0], win_next[26]};
                            h_c     = {18'd0, win_next[29][5:0], win_next[28]};
                            found_c = 1'b1;
                        end
                    end
                    else if (win_next[15] == "L")
                    begin
                        if (offset_next >= OFFSET_BITS'(25))
                        begin
                            w_c     = {18'd0, vp8l_bits[13:0]} + 32'd1;
                            h_c     = {18'd0, vp8l_bits[27:14]} + 32'd1;
                            found_c = 1'b1;
                        end
                    end
                    else if (win_next[15] == "X")
                    begin
                        if (offset_next >= OFFSET_BITS'(30))
                        begin
                            w_c     = {8'd0, win_next[26], win_next[25], win_next[24]} + 32'd1;
                            h_c     = {8'd0, win_next[29], win_next[28], win_next[27]} + 32'd1;
                            found_c = 1'b1;
                        end
                    end
                    else
                        found_c = 1'b0;
                end
            end
            else
                fmt_c = FMT_UNKNOWN;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (a_adv && a_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && a_last_reg)
        begin
            format_reg     <= fmt_c;
            width_reg      <= w_c;
            height_reg     <= h_c;
            size_valid_reg <= found_c && (w_c != 32'd0) && (h_c != 32'd0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign format     = format_reg;
    assign width      = width_reg;
    assign height     = height_reg;
    assign size_valid = size_valid_reg;

    // checks
    `IHSS_ASSERT_NEXT(a_result_after_last, a_adv && a_last_reg, out_valid_reg && offset_reg == '0, "no result or offset kept after last byte")
    `IHSS_ASSERT_NOW(a_valid_has_size, out_valid_reg && size_valid_reg, width_reg != 32'd0 && height_reg != 32'd0, "size flagged valid with zero dimension")
    `IHSS_ASSERT_NOW(a_unknown_no_size, out_valid_reg && format_reg == FMT_UNKNOWN, !size_valid_reg, "size flagged valid for unknown format")
    `IHSS_ASSERT_NEXT(a_no_overwrite, out_valid_reg && !out_ready, out_valid_reg && $stable(width_reg), "held result overwritten")

endmodule

// ----- bench/image_header_size_sniffer_tb.sv -----
// ----------------------------------------------------------------------------
// image_header_size_sniffer_tb
// streams small image files (jpeg marker chains, png, gif, riff/webp chunks,
// short, truncated and corrupted files, plain noise) through the sniffer
// under bursty input and a stalling receiver; every report is compared
// field by field with a bit-true prediction kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_header_size_sniffer_tb;
    import ihss_pkg::*;

    localparam int          OFFSET_BITS   = 32;
    localparam logic [63:0] OFFSET_LIMIT  = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam int          WIN_LEN       = 30;
    localparam int          RANDOM_BYTES  = 1900;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          MAX_SHOWN     = 10;

    // jpeg marker codes
    localparam logic [7:0]  MRK_PREFIX = 8'hFF;
    localparam logic [7:0]  MRK_SOI    = 8'hD8;
    localparam logic [7:0]  MRK_SOF_LO = 8'hC0;
    localparam logic [7:0]  MRK_SOF_HI = 8'hCF;
    localparam logic [7:0]  MRK_DHT    = 8'hC4;
    localparam logic [7:0]  MRK_JPG    = 8'hC8;
    localparam logic [7:0]  MRK_DAC    = 8'hCC;
    localparam logic [7:0]  MRK_DQT    = 8'hDB;
    localparam logic [7:0]  MRK_APP0   = 8'hE0;
    localparam logic [7:0]  MRK_COM    = 8'hFE;
    localparam logic [7:0]  SOF_PREC   = 8'h08;

    // signatures and chunk tags
    localparam logic [23:0] SIG_JPEG  = 24'hFFD8FF;
    localparam logic [63:0] SIG_PNG   = 64'h89504E470D0A1A0A;
    localparam logic [47:0] SIG_GIF87 = "GIF87a";
    localparam logic [47:0] SIG_GIF89 = "GIF89a";
    localparam logic [31:0] TAG_RIFF  = "RIFF";
    localparam logic [31:0] TAG_WEBP  = "WEBP";
    localparam logic [31:0] TAG_IHDR  = "IHDR";
    localparam logic [31:0] TAG_VP8   = "VP8 ";
    localparam logic [31:0] TAG_VP8L  = "VP8L";
    localparam logic [31:0] TAG_VP8X  = "VP8X";
    localparam logic [31:0] VP8_MASK  = 32'h0000_3FFF;

    typedef enum int {
        KIND_JPEG, KIND_PNG, KIND_GIF, KIND_VP8, KIND_VP8L, KIND_VP8X, KIND_RIFF, KIND_NOISE
    } file_kind_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;   // wait for all reports before offering this word
    } byte_word_t;

    typedef struct {
        logic [2:0]  fmt;
        logic [31:0] w;
        logic [31:0] h;
        logic        ok;
    } size_report_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte  = 8'h00;
    logic        last_byte  = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [2:0]  format;
    logic [31:0] width;
    logic [31:0] height;
    logic        size_valid;

    image_header_size_sniffer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .format     (format),
        .width      (width),
        .height     (height),
        .size_valid (size_valid)
    );

    byte_word_t   pending_bytes[$];
    logic [7:0]   file_bytes[$];
    size_report_t expected_sizes[$];

    int file_total     = 0;
    int bytes_sent     = 0;
    int reports_seen   = 0;
    int mismatch_count = 0;
    int usable_count   = 0;
    int format_tally[5];

    // sniffer state as the bench sees it
    logic [7:0]  hdr_win [WIN_LEN];
    logic [63:0] byte_count;
    logic [63:0] seg_start;
    logic [15:0] seg_len;
    logic [7:0]  seg_marker;
    logic        in_frame;
    logic [31:0] frame_dims;     // height in 31..16, width in 15..0
    logic        frame_seen;
    logic        walk_halted;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_frame_marker(input logic [7:0] m);
        return (m >= MRK_SOF_LO) && (m <= MRK_SOF_HI) &&
               (m != MRK_DHT) && (m != MRK_JPG) && (m != MRK_DAC);
    endfunction

    // n window bytes from offset at, first byte most significant
    function automatic logic [63:0] win_bytes(input int at, input int n);
        logic [63:0] v;
        v = 64'd0;
        for (int i = 0; i < n; i++)
            v = {v[55:0], hdr_win[at + i]};
        return v;
    endfunction

    task automatic clear_sniffer();
        for (int i = 0; i < WIN_LEN; i++)
            hdr_win[i] = 8'h00;
        byte_count  = 64'd0;
        seg_start   = 64'd2;
        seg_len     = 16'd0;
        seg_marker  = 8'h00;
        in_frame    = 1'b0;
        frame_dims  = 32'd0;
        frame_seen  = 1'b0;
        walk_halted = 1'b0;
    endtask

    // advance the prediction by one accepted word; a last byte yields a report
    task automatic sniff_byte(input logic [7:0] b, input logic last);
        logic [63:0]  o;
        logic [63:0]  k;
        logic [63:0]  step;
        logic [63:0]  total;
        logic [31:0]  bits;
        logic         found;
        size_report_t r;
        o = byte_count;
        if (o < OFFSET_LIMIT)
        begin
            if (o < WIN_LEN) hdr_win[o[4:0]] = b;
            // jpeg marker walk
            if (!walk_halted && !frame_seen && o >= seg_start)
            begin
                k = o - seg_start;
                if (k == 64'd0)
                begin
                    if (b != MRK_PREFIX) walk_halted = 1'b1;
                end
                else if (k == 64'd1)
                    seg_marker = b;
                else if (k == 64'd2)
                    seg_len = {b, 8'h00};
                else if (k == 64'd3)
                begin
                    seg_len[7:0] = b;
                    if (is_frame_marker(seg_marker))
                        in_frame = 1'b1;
                    else if (seg_len < 16'd2)
                        walk_halted = 1'b1;
                    else
                    begin
                        step = 64'(seg_len) + 64'd2;
                        seg_start = (step > OFFSET_LIMIT - seg_start) ? OFFSET_LIMIT
                                                                      : seg_start + step;
                    end
                end
                else if (in_frame)
                begin
                    case (k)
                        64'd5:   frame_dims[31:24] = b;
                        64'd6:   frame_dims[23:16] = b;
                        64'd7:   frame_dims[15:8]  = b;
                        64'd8:   frame_dims[7:0]   = b;
                        64'd9:   frame_seen        = 1'b1;
                        default: ;
                    endcase
                end
            end
            byte_count = o + 64'd1;
        end
        if (last)
        begin
            total = byte_count;
            found = 1'b0;
            r.fmt = FMT_UNKNOWN;
            r.w   = 32'd0;
            r.h   = 32'd0;
            if (total >= 64'd12)
            begin
                if (win_bytes(0, 3) == 64'(SIG_JPEG))
                begin
                    r.fmt = FMT_JPEG;
                    if (frame_seen)
                    begin
                        r.h   = {16'd0, frame_dims[31:16]};
                        r.w   = {16'd0, frame_dims[15:0]};
                        found = 1'b1;
                    end
                end
                else if (win_bytes(0, 8) == SIG_PNG)
                begin
                    r.fmt = FMT_PNG;
                    if (total >= 64'd24 && win_bytes(12, 4) == 64'(TAG_IHDR))
                    begin
                        r.w   = win_bytes(16, 4);
                        r.h   = win_bytes(20, 4);
                        found = 1'b1;
                    end
                end
                else if (win_bytes(0, 6) == 64'(SIG_GIF87) || win_bytes(0, 6) == 64'(SIG_GIF89))
                begin
                    r.fmt = FMT_GIF;
                    r.w   = {16'd0, hdr_win[7], hdr_win[6]};
                    r.h   = {16'd0, hdr_win[9], hdr_win[8]};
                    found = 1'b1;
                end
                else if (win_bytes(0, 4) == 64'(TAG_RIFF))
                begin
                    // riff counts as webp whatever follows
                    r.fmt = FMT_WEBP;
                    if (total >= 64'd16 && win_bytes(8, 4) == 64'(TAG_WEBP))
                    begin
                        if (win_bytes(12, 4) == 64'(TAG_VP8))
                        begin
                            if (total >= 64'd30)
                            begin
                                r.w   = {16'd0, hdr_win[27], hdr_win[26]} & VP8_MASK;
                                r.h   = {16'd0, hdr_win[29], hdr_win[28]} & VP8_MASK;
                                found = 1'b1;
                            end
                        end
                        else if (win_bytes(12, 4) == 64'(TAG_VP8L))
                        begin
                            if (total >= 64'd25)
                            begin
                                bits  = {hdr_win[24], hdr_win[23], hdr_win[22], hdr_win[21]};
                                r.w   = {18'd0, bits[13:0]} + 32'd1;
                                r.h   = {18'd0, bits[27:14]} + 32'd1;
                                found = 1'b1;
                            end
                        end
                        else if (win_bytes(12, 4) == 64'(TAG_VP8X))
                        begin
                            if (total >= 64'd30)
                            begin
                                r.w   = {8'd0, hdr_win[26], hdr_win[25], hdr_win[24]} + 32'd1;
                                r.h   = {8'd0, hdr_win[29], hdr_win[28], hdr_win[27]} + 32'd1;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            r.ok = found && (r.w != 32'd0) && (r.h != 32'd0);
            expected_sizes.insert(expected_sizes.size(), r);
            format_tally[r.fmt]++;
            if (r.ok) usable_count++;
            clear_sniffer();
        end
    endtask

    // file building helpers
    task automatic add_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            file_bytes.insert(file_bytes.size(), v[i*8 +: 8]);
    endtask

    task automatic add_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.insert(file_bytes.size(), v[i*8 +: 8]);
    endtask

    task automatic add_rand(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.insert(file_bytes.size(), 8'($urandom));
    endtask

    // dimension bytes lean towards the extremes
    task automatic add_dims(input int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       file_bytes.insert(file_bytes.size(), 8'h00);
                1:       file_bytes.insert(file_bytes.size(), 8'hFF);
                default: file_bytes.insert(file_bytes.size(), 8'($urandom));
            endcase
        end
    endtask

    task automatic queue_file(input bit hold);
        byte_word_t wd;
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            wd.data = file_bytes[i];
            wd.last = (i == file_bytes.size() - 1);
            wd.hold = hold && (i == 0);
            pending_bytes.insert(pending_bytes.size(), wd);
        end
        file_bytes.delete();
        file_total++;
    endtask

    // stimulus, reset and end of run
    initial
    begin
        file_kind_t kind;
        int         nseg;
        int         seg;
        int         keep;
        int         idx;
        int         directed_count;
        logic [7:0] mk;

        for (int i = 0; i < 5; i++)
            format_tally[i] = 0;
        clear_sniffer();

        // a one-byte file
        add_be(64'(MRK_PREFIX), 1);
        queue_file(1'b0);
        // gif signature one byte short of the minimum length
        add_be(64'(SIG_GIF87), 6);
        add_le(64'h0001, 2);
        add_le(64'h0001, 2);
        add_be(64'h00, 1);
        queue_file(1'b0);
        // shortest gif, widest width and a zero height
        add_be(64'(SIG_GIF89), 6);
        add_le(64'hFFFF, 2);
        add_le(64'h0000, 2);
        add_be(64'h00FF, 2);
        queue_file(1'b0);
        directed_count = pending_bytes.size();

        while (pending_bytes.size() < directed_count + RANDOM_BYTES)
        begin
            kind = file_kind_t'($urandom_range(0, 7));
            case (kind)
                KIND_JPEG:
                begin
                    add_be(64'({MRK_PREFIX, MRK_SOI}), 2);
                    nseg = $urandom_range(0, 3);
                    for (int s = 0; s < nseg; s++)
                    begin
                        // now and then the chain is broken by a stray byte
                        if ($urandom_range(0, 15) == 0) add_rand(1);
                        else add_be(64'(MRK_PREFIX), 1);
                        case ($urandom_range(0, 6))
                            0:       mk = MRK_DHT;
                            1:       mk = MRK_JPG;
                            2:       mk = MRK_DAC;
                            3:       mk = MRK_DQT;
                            4:       mk = MRK_APP0;
                            5:       mk = MRK_COM;
                            default: mk = 8'($urandom);
                        endcase
                        add_be(64'(mk), 1);
                        seg = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1)
                                                           : $urandom_range(2, 18);
                        add_be(64'(seg), 2);
                        if (seg >= 2) add_rand(seg - 2);
                    end
                    // start of frame segment
                    add_be(64'(MRK_PREFIX), 1);
                    mk = 8'($urandom_range(MRK_SOF_LO, MRK_SOF_HI));
                    while (!is_frame_marker(mk))
                        mk = 8'($urandom_range(MRK_SOF_LO, MRK_SOF_HI));
                    add_be(64'(mk), 1);
                    add_be(64'($urandom_range(8, 17)), 2);
                    add_be(64'(SOF_PREC), 1);
                    add_dims(4);
                    add_rand($urandom_range(1, 6));
                end
                KIND_PNG:
                begin
                    add_be(SIG_PNG, 8);
                    add_rand(4);
                    if ($urandom_range(0, 7) == 0) add_rand(4);
                    else add_be(64'(TAG_IHDR), 4);
                    add_dims(8);
                    add_rand($urandom_range(0, 6));
                end
                KIND_GIF:
                begin
                    add_be(64'($urandom_range(0, 1) ? SIG_GIF87 : SIG_GIF89), 6);
                    add_dims(4);
                    add_rand($urandom_range(1, 8));
                end
                KIND_VP8, KIND_VP8L, KIND_VP8X:
                begin
                    add_be(64'(TAG_RIFF), 4);
                    add_rand(4);
                    add_be(64'(TAG_WEBP), 4);
                    if (kind == KIND_VP8)
                    begin
                        add_be(64'(TAG_VP8), 4);
                        add_rand(10);
                        add_dims(4);
                    end
                    else if (kind == KIND_VP8L)
                    begin
                        add_be(64'(TAG_VP8L), 4);
                        add_rand(5);
                        add_dims(4);
                    end
                    else
                    begin
                        add_be(64'(TAG_VP8X), 4);
                        add_rand(8);
                        add_dims(6);
                    end
                    add_rand($urandom_range(0, 6));
                end
                KIND_RIFF:
                begin
                    add_be(64'(TAG_RIFF), 4);
                    add_rand($urandom_range(4, 20));
                end
                default:
                    add_rand($urandom_range(1, 40));
            endcase
            // truncated files and single bit damage
            if ($urandom_range(0, 5) == 0)
            begin
                keep = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > keep)
                    mk = file_bytes.pop_back();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                idx = $urandom_range(0, file_bytes.size() - 1);
                file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            queue_file((file_total % 20) == 10);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid || expected_sizes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d files in %0d bytes: jpeg %0d, png %0d, gif %0d, webp %0d, unknown %0d",
                 file_total, bytes_sent, format_tally[FMT_JPEG], format_tally[FMT_PNG],
                 format_tally[FMT_GIF], format_tally[FMT_WEBP], format_tally[FMT_UNKNOWN]);
        $display("%0d reports checked, %0d with a usable size, %0d mismatches",
                 reports_seen, usable_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // input driver: bursts with random gaps, held until accepted
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                sniff_byte(data_byte, last_byte);
                void'(pending_bytes.pop_front());
                bytes_sent++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() == 0 ||
                         (pending_bytes[0].hold && expected_sizes.size() != 0))
                    in_valid <= 1'b0;
                else
                begin
                    in_valid  <= 1'b1;
                    data_byte <= pending_bytes[0].data;
                    last_byte <= pending_bytes[0].last;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver: runs of ready, runs of stall and short choppy stretches
    int rx_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_left = 0;
        end
        else if (rx_left > 0)
            rx_left--;
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    out_ready <= 1'b0;
                    rx_left = $urandom_range(1, 10);
                end
                1:
                begin
                    out_ready <= 1'b1;
                    rx_left = $urandom_range(50, 200);
                end
                default:
                begin
                    out_ready <= 1'($urandom_range(0, 1));
                    rx_left = $urandom_range(0, 3);
                end
            endcase
        end
    end

    // result monitor
    size_report_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen++;
            if (expected_sizes.size() == 0)
            begin
                if (mismatch_count < MAX_SHOWN)
                    $display("%t: unexpected report fmt %0d w %0d h %0d valid %0b",
                             $realtime, format, width, height, size_valid);
                mismatch_count++;
            end
            else
            begin
                want = expected_sizes.pop_front();
                if (format !== want.fmt || width !== want.w || height !== want.h ||
                    size_valid !== want.ok)
                begin
                    if (mismatch_count < MAX_SHOWN)
                        $display("%t: report %0d expected fmt %0d w %0d h %0d valid %0b, got fmt %0d w %0d h %0d valid %0b",
                                 $realtime, reports_seen, want.fmt, want.w, want.h, want.ok,
                                 format, width, height, size_valid);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%t: no handshake for %0d cycles, %0d reports outstanding",
                         $realtime, idle_cycles, expected_sizes.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ihss_pkg.sv
sv/ihss_jpeg_walk.sv
sv/image_header_size_sniffer.sv
bench/image_header_size_sniffer_tb.sv
